@@ rtl/core/mck_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, register indexes and the Morse pattern table of the keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

   localparam int CharWidth  = 8;
   localparam int DurWidth   = 16;
   localparam int CsrIdxW    = 3;
   localparam int PatWidth   = 5;
   localparam int CntWidth   = 3;
   localparam int NumSym     = 36;
   localparam int SymIdxW    = 6;

   localparam logic [CsrIdxW-1:0] REG_DOT        = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_DASH       = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_ELEM_GAP   = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_LETTER_GAP = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_WORD_GAP   = 3'd4;

   localparam logic [DurWidth-1:0] RST_DOT        = 16'd100;
   localparam logic [DurWidth-1:0] RST_DASH       = 16'd300;
   localparam logic [DurWidth-1:0] RST_ELEM_GAP   = 16'd100;
   localparam logic [DurWidth-1:0] RST_LETTER_GAP = 16'd300;
   localparam logic [DurWidth-1:0] RST_WORD_GAP   = 16'd700;

   localparam logic [CharWidth-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CharWidth-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CharWidth-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CharWidth-1:0] CASE_OFFSET  = 8'h20;
   localparam logic [SymIdxW-1:0]   DIGIT_BASE   = 6'd26;

   // element count per symbol, A..Z then 0..9
   localparam logic [CntWidth-1:0] SYM_LEN [NumSym] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
      3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
      3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };

   // element bits, first element in highest used bit, 1 = dash
   localparam logic [PatWidth-1:0] SYM_BITS [NumSym] = '{
      5'd1,  5'd8,  5'd10, 5'd4,  5'd0,  5'd2,  5'd6,  5'd0,  5'd0,  5'd7,
      5'd5,  5'd4,  5'd3,  5'd2,  5'd7,  5'd6,  5'd13, 5'd2,  5'd0,  5'd1,
      5'd1,  5'd1,  5'd3,  5'd9,  5'd11, 5'd12,
      5'd31, 5'd15, 5'd7,  5'd3,  5'd1,  5'd0,  5'd16, 5'd24, 5'd28, 5'd30
   };

   typedef enum logic [1:0] {
      CLASS_OTHER,
      CLASS_SPACE,
      CLASS_SYMBOL
   } char_class_type;

   typedef enum logic [1:0] {
      EMIT_ELEM,
      EMIT_EGAP,
      EMIT_LGAP,
      EMIT_WGAP
   } emit_kind_type;

   typedef struct packed {
      logic          load_char;
      logic          emit;
      emit_kind_type kind;
   } mck_cmd_type;

   typedef struct packed {
      char_class_type char_class;
      logic           last_elem;
   } mck_status_type;

endpackage
`default_nettype wire

@@ rtl/core/mck_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mck_datapath
// Timing registers, character decode, element shifter and result register.
// ----------------------------------------------------------------------------
module mck_datapath import mck_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [DurWidth-1:0]  csr_write_data,
   input  wire logic [CharWidth-1:0] req_character,
   input  wire mck_cmd_type          cmd,
   output mck_status_type            status,
   output logic                      rsp_key_on,
   output logic [DurWidth-1:0]       rsp_duration,
   output logic                      rsp_last
);

   logic [DurWidth-1:0]  dot_ff, dash_ff, egap_ff, lgap_ff, wgap_ff;
   logic [PatWidth-1:0]  pat_ff, pat_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 key_ff, key_in;
   logic [DurWidth-1:0]  dur_ff, dur_in;
   logic                 last_ff, last_in;

   logic [CharWidth-1:0] folded;
   logic [CharWidth-1:0] sym_wide;
   logic [SymIdxW-1:0]   sym;
   char_class_type       cls;
   logic [CntWidth-1:0]  sym_len;
   logic [PatWidth-1:0]  sym_bits;

   always_comb begin
      folded = req_character;
      if (req_character >= CHAR_LOWER_A && req_character <= CHAR_LOWER_Z) begin
         folded = req_character - CASE_OFFSET;
      end
      cls      = CLASS_OTHER;
      sym_wide = '0;
      if (folded == CHAR_SPACE) begin
         cls = CLASS_SPACE;
      end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
         cls      = CLASS_SYMBOL;
         sym_wide = folded - CHAR_UPPER_A;
      end else if (folded >= CHAR_ZERO && folded <= CHAR_NINE) begin
         cls      = CLASS_SYMBOL;
         sym_wide = folded - CHAR_ZERO + {2'b00, DIGIT_BASE};
      end
      sym      = sym_wide[SymIdxW-1:0];
      sym_len  = SYM_LEN[sym];
      sym_bits = SYM_BITS[sym];
   end

   assign status.char_class = cls;
   assign status.last_elem  = (cnt_ff == CntWidth'(1));

   always_comb begin
      pat_in  = pat_ff;
      cnt_in  = cnt_ff;
      key_in  = key_ff;
      dur_in  = dur_ff;
      last_in = last_ff;
      if (cmd.load_char) begin
         pat_in = PatWidth'(sym_bits << (CntWidth'(PatWidth) - sym_len));
         cnt_in = sym_len;
      end
      if (cmd.emit) begin
         unique case (cmd.kind)
            EMIT_ELEM: begin
               key_in  = 1'b1;
               dur_in  = pat_ff[PatWidth-1] ? dash_ff : dot_ff;
               last_in = 1'b0;
               pat_in  = {pat_ff[PatWidth-2:0], 1'b0};
               cnt_in  = cnt_ff - CntWidth'(1);
            end
            EMIT_EGAP: begin
               key_in  = 1'b0;
               dur_in  = egap_ff;
               last_in = 1'b0;
            end
            EMIT_LGAP: begin
               key_in  = 1'b0;
               dur_in  = lgap_ff;
               last_in = 1'b1;
            end
            EMIT_WGAP: begin
               key_in  = 1'b0;
               dur_in  = wgap_ff;
               last_in = 1'b1;
            end
            default: begin
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= RST_DOT;
         dash_ff <= RST_DASH;
         egap_ff <= RST_ELEM_GAP;
         lgap_ff <= RST_LETTER_GAP;
         wgap_ff <= RST_WORD_GAP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DOT:        dot_ff  <= csr_write_data;
            REG_DASH:       dash_ff <= csr_write_data;
            REG_ELEM_GAP:   egap_ff <= csr_write_data;
            REG_LETTER_GAP: lgap_ff <= csr_write_data;
            REG_WORD_GAP:   wgap_ff <= csr_write_data;
            default:        dot_ff  <= dot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      cnt_ff  <= cnt_in;
      key_ff  <= key_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
   end

   assign rsp_key_on   = key_ff;
   assign rsp_duration = dur_ff;
   assign rsp_last     = last_ff;

endmodule
`default_nettype wire

@@ rtl/core/mck_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mck_ctrl
// Sequencer: walks one character's elements and gaps, owns result valid.
// ----------------------------------------------------------------------------
module mck_ctrl import mck_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire mck_status_type status,
   output mck_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ELEM,
      S_EGAP,
      S_LGAP,
      S_WGAP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.load_char = 1'b0;
      cmd.emit      = 1'b0;
      cmd.kind      = EMIT_LGAP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_char = 1'b1;
               unique case (status.char_class)
                  CLASS_SPACE:  state_in = S_WGAP;
                  CLASS_SYMBOL: state_in = S_ELEM;
                  default:      state_in = S_LGAP;
               endcase
            end
         end
         S_ELEM: begin
            cmd.kind = EMIT_ELEM;
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = status.last_elem ? S_LGAP : S_EGAP;
            end
         end
         S_EGAP: begin
            cmd.kind = EMIT_EGAP;
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_ELEM;
            end
         end
         S_LGAP: begin
            cmd.kind = EMIT_LGAP;
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WGAP: begin
            cmd.kind = EMIT_WGAP;
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/morse_code_keyer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// morse_code_keyer_unit
// Turns ASCII characters into timed key-on / key-off results.
//
//   port group  direction  transfer when             content
//   req_*       in         req_valid & req_ready     character
//   rsp_*       out        rsp_valid & rsp_ready     key_on, duration, last
//   csr_*       in         csr_write_enable          index, 16-bit value
//
// The sequencer takes a character in idle, then gives one result per cycle
// while the output is free: letters and digits give 2n results (n elements),
// a space or any other character gives one; only then does it take the next.
// A stalled rsp_ready holds the result register and the sequencer.
// Synchronous reset restores the default timings and empties the output.
// ----------------------------------------------------------------------------
module morse_code_keyer_unit import mck_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CharWidth-1:0] req_character,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_key_on,
   output logic [DurWidth-1:0]       rsp_duration,
   output logic                      rsp_last,
   input  wire logic                 csr_write_enable,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [DurWidth-1:0]  csr_write_data
);

   mck_cmd_type    cmd;
   mck_status_type status;

   mck_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mck_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_character    (req_character),
      .cmd              (cmd),
      .status           (status),
      .rsp_key_on       (rsp_key_on),
      .rsp_duration     (rsp_duration),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

@@ dv/tb_morse_code_keyer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_code_keyer_unit
// Checks the Morse keyer against an independent model of its keying output.
// Characters go in over the req_ channel. For each accepted character the
// ledger spells out the expected key-on / key-off steps, and each rsp_
// transfer is compared in order. Timing registers are reprogrammed between
// phases, extremes included. The phases run with and without random idling
// on the request side and stalling on the response side.
// ----------------------------------------------------------------------------
module tb_morse_code_keyer_unit;
   import mck_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_CHARS = 78;
   localparam logic [CsrIdxW-1:0] REG_FIRST_SPARE = REG_WORD_GAP + 3'd1;

   typedef struct packed {
      logic                key_on;
      logic [DurWidth-1:0] duration;
      logic                last;
   } key_step_type;

   class keying_ledger;
      key_step_type        pending_steps[$];
      logic [DurWidth-1:0] dot_len  = RST_DOT;
      logic [DurWidth-1:0] dash_len = RST_DASH;
      logic [DurWidth-1:0] egap_len = RST_ELEM_GAP;
      logic [DurWidth-1:0] lgap_len = RST_LETTER_GAP;
      logic [DurWidth-1:0] wgap_len = RST_WORD_GAP;
      int                  mismatches = 0;

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [DurWidth-1:0] val);
         case (idx)
            REG_DOT:        dot_len  = val;
            REG_DASH:       dash_len = val;
            REG_ELEM_GAP:   egap_len = val;
            REG_LETTER_GAP: lgap_len = val;
            REG_WORD_GAP:   wgap_len = val;
            default: ;
         endcase
      endfunction

      function string pattern_of(logic [CharWidth-1:0] c);
         case (c)
            "A": return ".-";    "B": return "-...";  "C": return "-.-.";
            "D": return "-..";   "E": return ".";     "F": return "..-.";
            "G": return "--.";   "H": return "....";  "I": return "..";
            "J": return ".---";  "K": return "-.-";   "L": return ".-..";
            "M": return "--";    "N": return "-.";    "O": return "---";
            "P": return ".--.";  "Q": return "--.-";  "R": return ".-.";
            "S": return "...";   "T": return "-";     "U": return "..-";
            "V": return "...-";  "W": return ".--";   "X": return "-..-";
            "Y": return "-.--";  "Z": return "--..";
            "0": return "-----"; "1": return ".----"; "2": return "..---";
            "3": return "...--"; "4": return "....-"; "5": return ".....";
            "6": return "-...."; "7": return "--..."; "8": return "---..";
            "9": return "----.";
            default: return "";
         endcase
      endfunction

      function void push_step(logic key_on, logic [DurWidth-1:0] dur, logic last);
         key_step_type s;
         s.key_on   = key_on;
         s.duration = dur;
         s.last     = last;
         pending_steps.push_back(s);
      endfunction

      // accepted character: queue the keying it should produce
      function void take_char(logic [CharWidth-1:0] ch);
         logic [CharWidth-1:0] c;
         string                pat;
         c = ch;
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            c = c - CASE_OFFSET;
         if (c == CHAR_SPACE) begin
            push_step(1'b0, wgap_len, 1'b1);
            return;
         end
         pat = pattern_of(c);
         for (int i = 0; i < pat.len(); i++) begin
            push_step(1'b1, (pat[i] == "-") ? dash_len : dot_len, 1'b0);
            if (i + 1 < pat.len())
               push_step(1'b0, egap_len, 1'b0);
         end
         push_step(1'b0, lgap_len, 1'b1);
      endfunction

      function void match_step(logic key_on, logic [DurWidth-1:0] dur, logic last);
         key_step_type want;
         if (pending_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: key_on=%0b duration=%0d last=%0b",
                        key_on, dur, last);
            return;
         end
         want = pending_steps.pop_front();
         if (key_on !== want.key_on || dur !== want.duration || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: want key_on=%0b duration=%0d last=%0b, got %0b %0d %0b",
                        want.key_on, want.duration, want.last, key_on, dur, last);
         end
      endfunction

      function int pending();
         return pending_steps.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CharWidth-1:0] req_character = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_key_on;
   logic [DurWidth-1:0]  rsp_duration;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [DurWidth-1:0]  csr_write_data = '0;

   keying_ledger ledger = new();
   int           tx_idle_pct = 0;
   int           rx_stall_pct = 0;
   int           stall_cycles = 0;

   morse_code_keyer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_on       (rsp_key_on),
      .rsp_duration     (rsp_duration),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.match_step(rsp_key_on, rsp_duration, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // leaves req_valid high after the transfer; the next call decides
   task automatic send_char(input logic [CharWidth-1:0] ch);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      do @(posedge clock); while (!req_ready);
      ledger.take_char(ch);
   endtask

   function automatic logic [CharWidth-1:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CHAR_UPPER_A + 8'($urandom_range(0, 25));
         4, 5:       return CHAR_LOWER_A + 8'($urandom_range(0, 25));
         6:          return CHAR_ZERO + 8'($urandom_range(0, 9));
         7:          return CHAR_SPACE;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic [DurWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      ledger.write_reg(idx, val);
   endtask

   task automatic program_timing(input logic [DurWidth-1:0] dot, dash, egap, lgap, wgap,
                                 input bit spare);
      csr_put(REG_DOT, dot);
      csr_put(REG_DASH, dash);
      csr_put(REG_ELEM_GAP, egap);
      csr_put(REG_LETTER_GAP, lgap);
      csr_put(REG_WORD_GAP, wgap);
      if (spare)
         csr_put(REG_FIRST_SPARE + CsrIdxW'($urandom_range(0, 2)),
                 DurWidth'($urandom_range(0, 65535)));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      repeat (PHASE_CHARS) send_char(pick_char());
      settle();
   endtask

   function automatic logic [DurWidth-1:0] any_len();
      return DurWidth'($urandom_range(0, 65535));
   endfunction

   initial begin
      string opening;
      logic [CharWidth-1:0] odd_codes[5];
      opening = "AaZz09ET5 @[`{/:!Q";
      odd_codes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h1F};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < opening.len(); i++)
         send_char(opening[i]);
      foreach (odd_codes[i])
         send_char(odd_codes[i]);
      run_phase(0, 0);

      program_timing(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1);
      run_phase(70, 0);

      // zero dot and dash lengths give zero-length key-on steps
      program_timing(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
      run_phase(0, 70);

      program_timing(any_len(), any_len(), any_len(), any_len(), any_len(), 1'b1);
      run_phase(30, 30);

      program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      run_phase(0, 0);

      program_timing(any_len(), any_len(), any_len(), any_len(), any_len(), 1'b1);
      run_phase(30, 30);

      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
